### hdl/psmmc_pkg.sv
// ----------------------------------------------------------------------------
// psmmc_pkg
// Shared types and constants of the pixel stack mean/median combiner.
// ----------------------------------------------------------------------------
package psmmc_pkg;

  // Frame stack geometry and sample format
  localparam int MAX_FRAMES = 16;
  localparam int SAMPLE_W   = 20;
  localparam int FILL_W     = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_FRAMES);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  // Combine modes
  localparam logic MODE_MEAN   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  // Magnitude divider: one quotient bit per cycle
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = $clog2(MAX_FRAMES);

  // Controller commands to the datapath
  typedef struct packed {
    logic ins;       // insert accepted sample, add to sum
    logic div_init;  // load divider from running sum
    logic div_step;  // one restoring division step
    logic div_fix;   // apply sign to quotient, store result
    logic med_hi;    // read upper middle sample
    logic med_lo;    // read lower middle sample, form half-sum
    logic load;      // move result to output, clear stack
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic complete;  // the sample being offered completes the stack
    logic median;    // current combine mode is median
    logic n_odd;     // samples held is odd
    logic div_last;  // divider on its final step
  } sts_t;

endpackage

### hdl/psmmc_dp.sv
// ----------------------------------------------------------------------------
// psmmc_dp
// Datapath: configuration registers, sorted sample buffer, running sum,
// serial divider and output register.
// ----------------------------------------------------------------------------
module psmmc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [psmmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [psmmc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [psmmc_pkg::SAMPLE_W-1:0] sample_i,
  input  psmmc_pkg::cmd_t                       cmd_i,
  output psmmc_pkg::sts_t                       sts_o,
  output logic signed [psmmc_pkg::SAMPLE_W-1:0] combined_o
);

  localparam int SW = psmmc_pkg::SAMPLE_W;
  localparam int FW = psmmc_pkg::FILL_W;
  localparam int NF = psmmc_pkg::MAX_FRAMES;

  logic                                  mode_q;
  logic [psmmc_pkg::COUNT_W-1:0]         count_q;
  logic signed [SW-1:0]                  buf_q [NF];
  logic [FW-1:0]                         fill_q;
  logic signed [psmmc_pkg::SUM_W-1:0]    sum_q;
  logic [NF-1:0]                         le;
  logic [FW-1:0]                         fill_inc;
  logic [FW-1:0]                         eff_count;
  logic [psmmc_pkg::IDX_W-1:0]           rd_idx;
  logic signed [SW-1:0]                  rd_data;
  logic signed [SW-1:0]                  hi_q;
  logic signed [SW:0]                    pair_sum;
  logic signed [SW-1:0]                  res_q;
  logic signed [SW-1:0]                  combined_q;
  logic [psmmc_pkg::REM_W-1:0]           rem_q;
  logic [psmmc_pkg::SUM_W-1:0]           quo_q;
  logic                                  neg_q;
  logic [psmmc_pkg::DIV_CNT_W-1:0]       cnt_q;
  logic [psmmc_pkg::REM_W:0]             trial;
  logic                                  trial_ge;
  logic [psmmc_pkg::SUM_W-1:0]           sum_mag;
  logic [SW-1:0]                         quo_lo;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= psmmc_pkg::MODE_MEDIAN;
      count_q <= psmmc_pkg::COUNT_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == psmmc_pkg::CFG_MODE) begin
        mode_q <= cfg_data_i[0];
      end else if (cfg_index_i == psmmc_pkg::CFG_COUNT) begin
        count_q <= cfg_data_i[psmmc_pkg::COUNT_W-1:0];
      end
    end
  end

  // Clamp the stack count to 1..MAX_FRAMES
  always_comb begin
    if (count_q == '0) begin
      eff_count = FW'(1);
    end else if (32'(count_q) > NF) begin
      eff_count = FW'(NF);
    end else begin
      eff_count = FW'(count_q);
    end
  end

  assign fill_inc = fill_q + FW'(1);

  // Keep entries at or below the new sample; they form a prefix of the buffer
  always_comb begin
    for (int k = 0; k < NF; k++) begin
      le[k] = (FW'(k) < fill_q) && (buf_q[k] <= sample_i);
    end
  end

  // Insert the sample: keep, shift up by one, or take the new value
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      for (int k = 0; k < NF; k++) begin
        if (le[k]) begin
          buf_q[k] <= buf_q[k];
        end else if (k > 0 && !le[(k > 0) ? k - 1 : 0]) begin
          buf_q[k] <= buf_q[(k > 0) ? k - 1 : 0];
        end else begin
          buf_q[k] <= sample_i;
        end
      end
    end
  end

  // Advance fill count and running sum, clear when the result leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.load) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.ins) begin
      fill_q <= fill_inc;
      sum_q  <= sum_q + psmmc_pkg::SUM_W'(sample_i);
    end
  end

  // Middle sample read, one address per cycle
  assign rd_idx   = cmd_i.med_lo ? psmmc_pkg::IDX_W'((fill_q >> 1) - FW'(1))
                                 : psmmc_pkg::IDX_W'(fill_q >> 1);
  assign rd_data  = buf_q[rd_idx];
  assign pair_sum = {hi_q[SW-1], hi_q} + {rd_data[SW-1], rd_data};

  // Serial restoring division of the sum magnitude by the count
  assign sum_mag  = sum_q[psmmc_pkg::SUM_W-1] ? psmmc_pkg::SUM_W'(-sum_q)
                                              : psmmc_pkg::SUM_W'(sum_q);
  assign trial    = {rem_q, quo_q[psmmc_pkg::SUM_W-1]};
  assign trial_ge = (trial >= (psmmc_pkg::REM_W + 1)'(fill_q));
  assign quo_lo   = quo_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= sum_mag;
      neg_q <= sum_q[psmmc_pkg::SUM_W-1];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? psmmc_pkg::REM_W'(trial - (psmmc_pkg::REM_W + 1)'(fill_q))
                        : psmmc_pkg::REM_W'(trial);
      quo_q <= {quo_q[psmmc_pkg::SUM_W-2:0], trial_ge};
      cnt_q <= cnt_q + psmmc_pkg::DIV_CNT_W'(1);
    end
  end

  // Form the result: signed quotient, middle sample or floored half-sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_fix) begin
      res_q <= neg_q ? SW'(-quo_lo) : SW'(quo_lo);
    end else if (cmd_i.med_hi) begin
      res_q <= rd_data;
      hi_q  <= rd_data;
    end else if (cmd_i.med_lo) begin
      res_q <= pair_sum[SW:1];
    end
  end

  // Hold the result for the output channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      combined_q <= res_q;
    end
  end

  assign combined_o      = combined_q;
  assign sts_o.complete  = (fill_inc >= eff_count);
  assign sts_o.median    = mode_q;
  assign sts_o.n_odd     = fill_q[0];
  assign sts_o.div_last  = (cnt_q == psmmc_pkg::DIV_CNT_W'(psmmc_pkg::DIV_STEPS - 1));

endmodule

### hdl/psmmc_ctrl.sv
// ----------------------------------------------------------------------------
// psmmc_ctrl
// Controller: sequences sample insertion, result forming and the output
// handshake.
// ----------------------------------------------------------------------------
module psmmc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  psmmc_pkg::sts_t sts_i,
  output psmmc_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MED_HI   = 7'b0000010,
    S_MED_LO   = 7'b0000100,
    S_DIV_INIT = 7'b0001000,
    S_DIV_RUN  = 7'b0010000,
    S_DIV_FIX  = 7'b0100000,
    S_LOAD     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.ins = 1'b1;
          if (sts_i.complete) begin
            state_d = sts_i.median ? S_MED_HI : S_DIV_INIT;
          end
        end
      end
      S_MED_HI: begin
        cmd_o.med_hi = 1'b1;
        state_d = sts_i.n_odd ? S_LOAD : S_MED_LO;
      end
      S_MED_LO: begin
        cmd_o.med_lo = 1'b1;
        state_d = S_LOAD;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DIV_FIX;
        end
      end
      S_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        // Wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/pixel_stack_mean_median_combine_top.sv
// ----------------------------------------------------------------------------
// pixel_stack_mean_median_combine_top
// Mean or median of one pixel position across a stack of frame samples.
// ----------------------------------------------------------------------------
// Samples arrive one per request and are inserted into a sorted buffer in the
// cycle they are accepted; a sample that does not complete the stack leaves
// the block ready for the next one. The sample that completes the stack starts
// the combine: median mode reads the middle sample(s) one buffer read per
// cycle (MED_HI, then MED_LO for an even count); mean mode runs a restoring
// divider at one quotient bit per cycle over the 24-bit sum. The divider sets
// the worst case. A result waits in the output register while the next stack
// fills; the result of the following stack then waits in LOAD until that
// register is taken. Writes to the configuration port are always accepted and
// do not clear a part-filled stack.
module pixel_stack_mean_median_combine_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [psmmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [psmmc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [psmmc_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [psmmc_pkg::SAMPLE_W-1:0] combined_o
);

  psmmc_pkg::cmd_t cmd;
  psmmc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequence each request
  psmmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, sort and combine samples
  psmmc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .combined_o  (combined_o)
  );

endmodule
